FILE: hw/rtl/mqpd_pkg.sv
// shared types and constants for the midi quartet packet deframer
package mqpd_pkg;

    // field widths
    localparam int unsigned ByteW  = 8;
    localparam int unsigned CountW = 17;
    localparam int unsigned CableW = 4;
    localparam int unsigned KindW  = 3;

    // result kinds
    typedef enum logic [KindW-1:0] {
        KIND_MIDI       = 3'd0,
        KIND_IGNORED    = 3'd1,
        KIND_KEEPALIVE  = 3'd2,
        KIND_BAD_SYNC   = 3'd3,
        KIND_BAD_LENGTH = 3'd4,
        KIND_BAD_RSVD   = 3'd5
    } t_kind;

    // header and quartet constants
    localparam logic [ByteW-1:0]  SYNC_BYTE      = 8'h02;
    localparam logic [ByteW-1:0]  CODE_MASK      = 8'h0F;
    localparam logic [ByteW-1:0]  END_MASK       = 8'h03;
    localparam logic [3:0]        CODE_THREE_A   = 4'h4;
    localparam logic [3:0]        CODE_ONE       = 4'h5;
    localparam logic [3:0]        CODE_TWO       = 4'h6;
    localparam logic [3:0]        CODE_THREE_B   = 4'h7;
    localparam logic [CountW-1:0] LEN_OFFSET     = 17'd4;
    localparam logic [CountW-1:0] MIN_FRAME_LEN  = 17'd8;
    localparam logic [CountW-1:0] BODY_START_POS = 17'd8;

    // up to three results caused by one byte, sharing all but the data byte
    typedef struct packed {
        logic [1:0]        cnt;
        t_kind             kind;
        logic [ByteW-1:0]  data0;
        logic [ByteW-1:0]  data1;
        logic [ByteW-1:0]  data2;
        logic [CableW-1:0] cable;
        logic              mis;
        logic              early;
        logic              fend;
    } t_result_group;

endpackage

FILE: hw/rtl/mqpd_parser.sv
// input register, frame parse state and per-byte result group logic
module mqpd_parser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [mqpd_pkg::ByteW-1:0]  i_s_tdata,
    output logic                        o_grp_valid,
    input  logic                        i_grp_ready,
    output mqpd_pkg::t_result_group     o_grp
);

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_RSVD = 2'd1,
        PH_BODY = 2'd2
    } t_phase;

    logic                         r_in_valid;
    logic [mqpd_pkg::ByteW-1:0]   r_in_byte;
    t_phase                       r_phase,        n_phase;
    logic [mqpd_pkg::CountW-1:0]  r_byte_count,   n_byte_count;
    logic [mqpd_pkg::CountW-1:0]  r_frame_length, n_frame_length;
    logic [mqpd_pkg::CableW-1:0]  r_cable,        n_cable;
    logic [mqpd_pkg::ByteW-1:0]   r_qhead,        n_qhead;
    logic [mqpd_pkg::ByteW-1:0]   r_qbytes [2];
    logic [mqpd_pkg::ByteW-1:0]   n_qbyte0,       n_qbyte1;

    logic [mqpd_pkg::CountW-1:0]  w_pos_inc;
    logic [mqpd_pkg::CountW-1:0]  w_len_sum;
    logic                         w_fend;
    logic                         w_fault;
    mqpd_pkg::t_kind              w_fault_kind;
    logic [3:0]                   w_code;
    logic                         w_adv;
    mqpd_pkg::t_result_group      w_grp;

    // shared arithmetic on the position and length
    assign w_pos_inc = r_byte_count + 17'd1;
    assign w_len_sum = {1'b0, r_frame_length[15:8], r_in_byte} + mqpd_pkg::LEN_OFFSET;
    assign w_fend    = ({1'b0, r_byte_count} + 18'd1) >= {1'b0, r_frame_length};
    assign w_code    = r_qhead[3:0];

    // parse one byte: next state and the results it causes
    always_comb begin
        n_phase        = r_phase;
        n_byte_count   = r_byte_count;
        n_frame_length = r_frame_length;
        n_cable        = r_cable;
        n_qhead        = r_qhead;
        n_qbyte0       = r_qbytes[0];
        n_qbyte1       = r_qbytes[1];
        w_fault        = 1'b0;
        w_fault_kind   = mqpd_pkg::KIND_BAD_SYNC;
        w_grp          = '0;
        unique case (r_phase)
            PH_HUNT: begin
                priority if (r_byte_count == '0) begin
                    if (r_in_byte != 8'h00 && r_in_byte != mqpd_pkg::SYNC_BYTE) begin
                        w_fault = 1'b1;
                    end else begin
                        n_qhead      = r_in_byte;
                        n_byte_count = 17'd1;
                    end
                end else if (r_byte_count == 17'd1) begin
                    if (r_in_byte != 8'h00) begin
                        w_fault = 1'b1;
                    end else begin
                        n_byte_count = 17'd2;
                    end
                end else if (r_byte_count == 17'd2) begin
                    if (r_qhead == 8'h00 && r_in_byte != 8'h00) begin
                        w_fault = 1'b1;
                    end else begin
                        n_frame_length = {1'b0, r_in_byte, 8'h00};
                        n_byte_count   = 17'd3;
                    end
                end else begin
                    // fourth header byte: keepalive or length low byte
                    if (r_qhead == 8'h00) begin
                        if (r_in_byte != 8'h00) begin
                            w_fault = 1'b1;
                        end else begin
                            w_grp.cnt    = 2'd1;
                            w_grp.kind   = mqpd_pkg::KIND_KEEPALIVE;
                            n_byte_count = '0;
                            n_qhead      = '0;
                        end
                    end else begin
                        n_frame_length = w_len_sum;
                        if (w_len_sum <= mqpd_pkg::MIN_FRAME_LEN || w_len_sum[1:0] != 2'd0) begin
                            w_fault      = 1'b1;
                            w_fault_kind = mqpd_pkg::KIND_BAD_LENGTH;
                        end else begin
                            n_phase      = PH_RSVD;
                            n_byte_count = 17'd4;
                        end
                    end
                end
            end
            PH_RSVD: begin
                if (r_in_byte != 8'h00) begin
                    w_fault      = 1'b1;
                    w_fault_kind = mqpd_pkg::KIND_BAD_RSVD;
                end else begin
                    n_byte_count = w_pos_inc;
                    if (w_pos_inc >= mqpd_pkg::BODY_START_POS) begin
                        n_phase = PH_BODY;
                    end
                end
            end
            default: begin
                // quartet body
                unique case (r_byte_count[1:0])
                    2'd0: begin
                        n_qhead = r_in_byte;
                        if (r_byte_count == mqpd_pkg::BODY_START_POS) begin
                            n_cable = r_in_byte[7:4];
                        end
                        n_byte_count = w_pos_inc;
                    end
                    2'd1: begin
                        n_qbyte0     = r_in_byte;
                        n_byte_count = w_pos_inc;
                    end
                    2'd2: begin
                        n_qbyte1     = r_in_byte;
                        n_byte_count = w_pos_inc;
                    end
                    default: begin
                        w_grp.cable = r_cable;
                        w_grp.mis   = r_qhead[7:4] != r_cable;
                        w_grp.early = ((r_qhead & mqpd_pkg::END_MASK) != 8'h00) && !w_fend;
                        w_grp.fend  = w_fend;
                        w_grp.kind  = mqpd_pkg::KIND_MIDI;
                        w_grp.data0 = r_qbytes[0];
                        w_grp.data1 = r_qbytes[1];
                        w_grp.data2 = r_in_byte;
                        priority if (w_code == mqpd_pkg::CODE_THREE_A ||
                                     w_code == mqpd_pkg::CODE_THREE_B) begin
                            w_grp.cnt = 2'd3;
                        end else if (w_code == mqpd_pkg::CODE_ONE) begin
                            w_grp.cnt = 2'd1;
                        end else if (w_code == mqpd_pkg::CODE_TWO) begin
                            w_grp.cnt = 2'd2;
                        end else begin
                            w_grp.cnt   = 2'd1;
                            w_grp.kind  = mqpd_pkg::KIND_IGNORED;
                            w_grp.data0 = '0;
                        end
                        if (w_fend) begin
                            n_phase      = PH_HUNT;
                            n_byte_count = '0;
                            n_qhead      = '0;
                        end else begin
                            n_byte_count = w_pos_inc;
                        end
                    end
                endcase
            end
        endcase
        // header fault: one error result, then hunt again
        if (w_fault) begin
            n_phase      = PH_HUNT;
            n_byte_count = '0;
            n_qhead      = '0;
            w_grp        = '0;
            w_grp.cnt    = 2'd1;
            w_grp.kind   = w_fault_kind;
        end
    end

    // bytes with no result never wait for the result stage
    assign w_adv       = r_in_valid && (w_grp.cnt == 2'd0 || i_grp_ready);
    assign o_s_tready  = !r_in_valid || w_adv;
    assign o_grp_valid = r_in_valid && (w_grp.cnt != 2'd0);
    assign o_grp       = w_grp;

    // input register and parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_phase        <= PH_HUNT;
            r_byte_count   <= '0;
            r_frame_length <= '0;
            r_cable        <= '0;
            r_qhead        <= '0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (w_adv) begin
                r_phase        <= n_phase;
                r_byte_count   <= n_byte_count;
                r_frame_length <= n_frame_length;
                r_cable        <= n_cable;
                r_qhead        <= n_qhead;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
        if (w_adv) begin
            r_qbytes[0] <= n_qbyte0;
            r_qbytes[1] <= n_qbyte1;
        end
    end

endmodule

FILE: hw/rtl/mqpd_serializer.sv
// result group register that sends its results one beat at a time
module mqpd_serializer (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_grp_valid,
    output logic                     o_grp_ready,
    input  mqpd_pkg::t_result_group  i_grp,
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    output logic [15:0]              o_m_tdata,
    output logic [2:0]               o_m_tuser,
    output logic                     o_m_tlast
);

    logic                     r_g_valid;
    logic [1:0]               r_idx;
    mqpd_pkg::t_result_group  r_grp;
    logic                     w_last;
    logic [7:0]               w_data;

    assign w_last      = r_idx == (r_grp.cnt - 2'd1);
    assign o_grp_ready = !r_g_valid || (i_m_tready && w_last);

    // data byte of the current result
    always_comb begin
        unique case (r_idx)
            2'd0:    w_data = r_grp.data0;
            2'd1:    w_data = r_grp.data1;
            default: w_data = r_grp.data2;
        endcase
    end

    assign o_m_tvalid = r_g_valid;
    assign o_m_tdata  = {1'b0, r_grp.fend, r_grp.early, r_grp.mis, r_grp.cable, w_data};
    assign o_m_tuser  = r_grp.kind;
    assign o_m_tlast  = w_last;

    // group valid and beat index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_valid <= 1'b0;
            r_idx     <= '0;
        end else if (i_grp_valid && o_grp_ready) begin
            r_g_valid <= 1'b1;
            r_idx     <= '0;
        end else if (r_g_valid && i_m_tready) begin
            if (w_last) begin
                r_g_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    // group payload
    always_ff @(posedge i_clk) begin
        if (i_grp_valid && o_grp_ready) begin
            r_grp <= i_grp;
        end
    end

endmodule

FILE: hw/rtl/midi_quartet_packet_deframer_top.sv
// top level of the midi quartet packet deframer
//
//   channel   direction   beat                          tdata / tuser / tlast
//   s side    in          one stream byte               raw_byte
//   m side    out         one decoded result            data, flags / kind / last
//
// one byte is taken every cycle when the result side keeps up
// a byte's results pass the input register and then the result group register
// a quartet's results leave one per cycle while the m side is ready, from the
// result group register, overlapping the next quartet's first three bytes
// a stalled m side holds the group; bytes that make no result still pass
// synchronous active-low reset returns the parser to hunting for a frame
module midi_quartet_packet_deframer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] raw_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [7:0] data_byte, [11:8] cable,
                                     // [12] cable_mismatch, [13] early_end,
                                     // [14] frame_end, [15] zero
    output logic [2:0]  o_m_tuser,   // [2:0] kind
    output logic        o_m_tlast    // last result of the byte
);

    logic                     w_grp_valid;
    logic                     w_grp_ready;
    mqpd_pkg::t_result_group  w_grp;

    // frame parser
    mqpd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_grp_valid (w_grp_valid),
        .i_grp_ready (w_grp_ready),
        .o_grp       (w_grp)
    );

    // result beats
    mqpd_serializer u_serializer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_grp_valid (w_grp_valid),
        .o_grp_ready (w_grp_ready),
        .i_grp       (w_grp),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

FILE: hw/rtl/mqpd_checker.sv
// port-level checks for the deframer top and their bind
module mqpd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic [2:0]  o_m_tuser,
    input logic        o_m_tlast
);

    // a stalled result beat holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) &&
            $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("result beat changed while stalled");

    // only midi bytes carry data
    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != mqpd_pkg::KIND_MIDI |-> o_m_tdata[7:0] == 8'h00)
        else $error("data byte set on a non-midi result");

    // keepalive and header faults are single results with no quartet flags
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == mqpd_pkg::KIND_KEEPALIVE ||
            o_m_tuser == mqpd_pkg::KIND_BAD_SYNC ||
            o_m_tuser == mqpd_pkg::KIND_BAD_LENGTH ||
            o_m_tuser == mqpd_pkg::KIND_BAD_RSVD)
        |-> o_m_tlast && o_m_tdata == 16'h0000)
        else $error("header result is not a lone clean beat");

    // only a midi byte can be followed by more results of the same byte
    a_multi_midi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> o_m_tuser == mqpd_pkg::KIND_MIDI)
        else $error("non-midi result not last of its byte");

    // flags of a multi-result group stay constant across its beats
    a_group_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && !o_m_tlast |=> o_m_tvalid &&
            o_m_tdata[15:8] == $past(o_m_tdata[15:8]))
        else $error("flags changed inside one byte's results");

endmodule

bind midi_quartet_packet_deframer_top mqpd_checker u_mqpd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

FILE: tb/midi_quartet_packet_deframer_top_tb.sv
`timescale 1ns / 1ps
// testbench for the midi quartet packet deframer: framed byte stream against a scoreboard
module midi_quartet_packet_deframer_top_tb;

    localparam int unsigned RANDOM_BYTES = 320;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam int unsigned DRAIN_LIMIT  = 20000;
    localparam int unsigned TAIL_CYCLES  = 8;
    localparam int unsigned OPENING_LEN  = 29;

    // keepalive, a three-quartet frame, a stray byte, then a length that is not whole quartets
    localparam logic [7:0] OPENING [OPENING_LEN] = '{
        8'h00, 8'h00, 8'h00, 8'h00,
        8'h02, 8'h00, 8'h00, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h17, 8'hFF, 8'h00, 8'h80,
        8'h16, 8'hAA, 8'h55, 8'h00,
        8'h2F, 8'h12, 8'h34, 8'h56,
        8'h55,
        8'h02, 8'h00, 8'h00, 8'h06
    };

    typedef enum logic [1:0] {
        SEEK_HEADER,
        RESERVED,
        QUARTETS
    } t_parse;

    // one decoded result beat as the block should send it
    typedef struct packed {
        mqpd_pkg::t_kind kind;
        logic [7:0]      data;
        logic [3:0]      cable;
        logic            mis;
        logic            early;
        logic            fend;
        logic            last;
    } t_midi_beat;

    class quartet_scoreboard;
        t_parse      parse;
        logic [16:0] byte_count;
        logic [16:0] frame_len;
        logic [3:0]  cable;
        logic [7:0]  head;
        logic [7:0]  body [2];
        t_midi_beat  awaited_q [$];
        int unsigned mismatches;

        function new();
            parse      = SEEK_HEADER;
            byte_count = '0;
            frame_len  = '0;
            cable      = '0;
            head       = '0;
            body[0]    = '0;
            body[1]    = '0;
            mismatches = 0;
        endfunction

        function int unsigned pending();
            return awaited_q.size();
        endfunction

        function void add(mqpd_pkg::t_kind k, logic [7:0] d, logic [3:0] c, logic m, logic e,
                          logic f, logic l);
            t_midi_beat r;
            r.kind  = k;
            r.data  = d;
            r.cable = c;
            r.mis   = m;
            r.early = e;
            r.fend  = f;
            r.last  = l;
            awaited_q = {awaited_q, r};
        endfunction

        // header fault: one error beat, then hunt from the next byte
        function void fault(mqpd_pkg::t_kind k);
            add(k, 8'h00, 4'h0, 1'b0, 1'b0, 1'b0, 1'b1);
            parse      = SEEK_HEADER;
            byte_count = '0;
            head       = '0;
        endfunction

        // advance the parser by one accepted byte and queue what it decodes
        function void note_byte(logic [7:0] b);
            logic [16:0] pos;
            logic [3:0]  code;
            logic        fend;
            logic        mis;
            logic        early;
            pos = byte_count;
            if (parse == SEEK_HEADER) begin
                if (pos == 0) begin
                    if (b != 8'h00 && b != mqpd_pkg::SYNC_BYTE) begin
                        fault(mqpd_pkg::KIND_BAD_SYNC);
                    end else begin
                        head       = b;
                        byte_count = 17'd1;
                    end
                end else if (pos == 1) begin
                    if (b != 8'h00) fault(mqpd_pkg::KIND_BAD_SYNC);
                    else byte_count = 17'd2;
                end else if (pos == 2) begin
                    if (head == 8'h00 && b != 8'h00) begin
                        fault(mqpd_pkg::KIND_BAD_SYNC);
                    end else begin
                        frame_len  = {1'b0, b, 8'h00};
                        byte_count = 17'd3;
                    end
                end else if (head == 8'h00) begin
                    // all-zero header is a keepalive
                    if (b != 8'h00) begin
                        fault(mqpd_pkg::KIND_BAD_SYNC);
                    end else begin
                        add(mqpd_pkg::KIND_KEEPALIVE, 8'h00, 4'h0, 1'b0, 1'b0, 1'b0, 1'b1);
                        byte_count = '0;
                        head       = '0;
                    end
                end else begin
                    frame_len = {1'b0, frame_len[15:8], b} + mqpd_pkg::LEN_OFFSET;
                    if (frame_len <= mqpd_pkg::MIN_FRAME_LEN ||
                        frame_len[1:0] != 2'b00) begin
                        fault(mqpd_pkg::KIND_BAD_LENGTH);
                    end else begin
                        parse      = RESERVED;
                        byte_count = 17'd4;
                    end
                end
            end else if (parse == RESERVED) begin
                if (b != 8'h00) begin
                    fault(mqpd_pkg::KIND_BAD_RSVD);
                end else begin
                    byte_count = pos + 17'd1;
                    if (byte_count >= mqpd_pkg::BODY_START_POS) parse = QUARTETS;
                end
            end else if (pos[1:0] == 2'd0) begin
                // quartet head, the frame's first one sets the cable
                head = b;
                if (pos == mqpd_pkg::BODY_START_POS) cable = b[7:4];
                byte_count = pos + 17'd1;
            end else if (pos[1:0] != 2'd3) begin
                body[pos[1]] = b;
                byte_count   = pos + 17'd1;
            end else begin
                // fourth byte completes the quartet
                fend  = (pos + 17'd1 >= frame_len);
                mis   = (head[7:4] != cable);
                early = ((head & mqpd_pkg::END_MASK) != 8'h00) && !fend;
                code  = head[3:0];
                if (code == mqpd_pkg::CODE_THREE_A || code == mqpd_pkg::CODE_THREE_B) begin
                    add(mqpd_pkg::KIND_MIDI, body[0], cable, mis, early, fend, 1'b0);
                    add(mqpd_pkg::KIND_MIDI, body[1], cable, mis, early, fend, 1'b0);
                    add(mqpd_pkg::KIND_MIDI, b, cable, mis, early, fend, 1'b1);
                end else if (code == mqpd_pkg::CODE_ONE) begin
                    add(mqpd_pkg::KIND_MIDI, body[0], cable, mis, early, fend, 1'b1);
                end else if (code == mqpd_pkg::CODE_TWO) begin
                    add(mqpd_pkg::KIND_MIDI, body[0], cable, mis, early, fend, 1'b0);
                    add(mqpd_pkg::KIND_MIDI, body[1], cable, mis, early, fend, 1'b1);
                end else begin
                    add(mqpd_pkg::KIND_IGNORED, 8'h00, cable, mis, early, fend, 1'b1);
                end
                if (fend) begin
                    parse      = SEEK_HEADER;
                    byte_count = '0;
                    head       = '0;
                end else begin
                    byte_count = pos + 17'd1;
                end
            end
        endfunction

        // compare one accepted result beat with the oldest expected one
        function void check_result(logic [15:0] tdata, logic [2:0] tuser, logic tlast);
            t_midi_beat  want;
            logic [15:0] want_data;
            if (awaited_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result beat: tdata=%h tuser=%0d tlast=%b",
                             tdata, tuser, tlast);
            end else begin
                want      = awaited_q.pop_front();
                want_data = {1'b0, want.fend, want.early, want.mis, want.cable, want.data};
                if (tdata !== want_data || tuser !== want.kind || tlast !== want.last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"result beat differs: expected tdata=%h tuser=%0d ",
                                  "tlast=%b, got tdata=%h tuser=%0d tlast=%b"},
                                 want_data, want.kind, want.last, tdata, tuser, tlast);
                end
            end
        endfunction
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    bit                no_idle = 1'b0;
    int unsigned       stream_bytes = 0;
    quartet_scoreboard board;

    midi_quartet_packet_deframer_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    // 4 ns clock
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // hard stop for a hung run
    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // send one byte beat after a random gap
    task automatic send_byte(logic [7:0] value);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge clk); while (s_tready !== 1'b1);
        board.note_byte(value);
        stream_bytes++;
    endtask

    // well-formed frame with random quartet content
    task automatic send_frame(int unsigned quartets);
        logic [15:0] len;
        logic [3:0]  cab;
        logic [3:0]  nib;
        logic [3:0]  code;
        len = 16'(4 + 4 * quartets);
        cab = 4'($urandom);
        send_byte(mqpd_pkg::SYNC_BYTE);
        send_byte(8'h00);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        repeat (4) send_byte(8'h00);
        repeat (quartets) begin
            code = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(4, 7)) : 4'($urandom);
            nib  = ($urandom_range(0, 4) != 0) ? cab : 4'($urandom);
            send_byte({nib, code});
            repeat (3) send_byte(8'($urandom));
        end
    endtask

    // hold the stream until every expected result has left
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
    endtask

    // result side with random back-pressure
    initial begin : result_sink
        int unsigned stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            m_tready <= 1'b1;
            do @(posedge clk); while (m_tvalid !== 1'b1);
            board.check_result(m_tdata, m_tuser, m_tlast);
            stall = no_idle ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // reset, directed opening, random frames, drain and verdict
    initial begin : stimulus
        logic [15:0] len;
        int unsigned pick;
        int unsigned guard;
        bit          long_done;
        board = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (OPENING[i]) send_byte(OPENING[i]);

        long_done = 1'b0;
        while (stream_bytes < OPENING_LEN + RANDOM_BYTES) begin
            // the first pass always drains, later ones now and then
            if (stream_bytes == OPENING_LEN || $urandom_range(0, 29) == 0)
                hold_until_drained();
            no_idle = ($urandom_range(0, 5) == 0);
            pick    = $urandom_range(0, 99);
            if (!long_done && stream_bytes > OPENING_LEN + RANDOM_BYTES / 2) begin
                long_done = 1'b1;
                send_frame($urandom_range(60, 64));
            end else if (pick < 10) begin
                repeat (4) send_byte(8'h00);
            end else if (pick < 70) begin
                if ($urandom_range(0, 9) == 0) send_frame($urandom_range(5, 12));
                else send_frame($urandom_range(1, 4));
            end else if (pick < 80) begin
                // broken header at each position
                case ($urandom_range(0, 4))
                    0: begin
                        send_byte(8'($urandom));
                    end
                    1: begin
                        send_byte(mqpd_pkg::SYNC_BYTE);
                        send_byte(8'($urandom_range(1, 255)));
                    end
                    2: begin
                        repeat (2) send_byte(8'h00);
                        send_byte(8'($urandom_range(1, 255)));
                    end
                    3: begin
                        repeat (3) send_byte(8'h00);
                        send_byte(8'($urandom_range(1, 255)));
                    end
                    default: begin
                        len = 16'($urandom);
                        if ($urandom_range(0, 1) != 0) len = 16'($urandom_range(0, 4));
                        else if (len[1:0] == 2'b00) len[0] = 1'b1;
                        send_byte(mqpd_pkg::SYNC_BYTE);
                        send_byte(8'h00);
                        send_byte(len[15:8]);
                        send_byte(len[7:0]);
                    end
                endcase
            end else if (pick < 88) begin
                // valid length, then a nonzero reserved byte
                len = {8'($urandom), 6'($urandom), 2'b00};
                if (len < 16'd8) len = 16'hFFFC;
                send_byte(mqpd_pkg::SYNC_BYTE);
                send_byte(8'h00);
                send_byte(len[15:8]);
                send_byte(len[7:0]);
                repeat ($urandom_range(0, 3)) send_byte(8'h00);
                send_byte(8'($urandom_range(1, 255)));
            end else begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            end
        end

        s_tvalid <= 1'b0;
        guard = 0;
        while (board.pending() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge clk);
            guard++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/mqpd_pkg.sv
hw/rtl/mqpd_parser.sv
hw/rtl/mqpd_serializer.sv
hw/rtl/midi_quartet_packet_deframer_top.sv
hw/rtl/mqpd_checker.sv
tb/midi_quartet_packet_deframer_top_tb.sv
